@@ hdl/reol_pkg.sv @@
// Shared widths, codes and sequencer type for the ring entry offset lookup.
package reol_pkg;

	// Field widths
	localparam int FUNC_W     = 1;
	localparam int ELEN_W     = 12;
	localparam int TAG_W      = 32;
	localparam int OFF_W      = 16;
	localparam int SLOT_OUT_W = 4;
	localparam int BOFF_W     = 12;

	// Stream payload widths
	localparam int S_TDATA_W = 64;  // 60 bits of fields, padded to whole bytes
	localparam int S_TUSER_W = 1;
	localparam int M_TDATA_W = 48;
	localparam int M_TUSER_W = 2;

	// Item kinds carried in s_tuser
	localparam logic [FUNC_W-1:0] FUNC_ADD  = 1'b0;
	localparam logic [FUNC_W-1:0] FUNC_FIND = 1'b1;

	// Sequencer states, one-hot
	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_WALK = 2'b10
	} seq_state_t;

endpackage

@@ hdl/reol_store.sv @@
// Entry store: length and tag memories, one write port, one registered read port.
module reol_store #(
	parameter int DEPTH = 16,
	parameter int LW    = 12,
	parameter int SW    = 4
) (
	input  logic                    clk,
	input  logic                    wr_en,
	input  logic [SW-1:0]           wr_addr,
	input  logic [LW-1:0]           wr_len,
	input  logic [reol_pkg::TAG_W-1:0] wr_tag,
	input  logic [SW-1:0]           rd_addr,
	output logic [LW-1:0]           rd_len,
	output logic [reol_pkg::TAG_W-1:0] rd_tag
);
	import reol_pkg::*;

	logic [LW-1:0]    len_mem [DEPTH];
	logic [TAG_W-1:0] tag_mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			len_mem[wr_addr] <= wr_len;
			tag_mem[wr_addr] <= wr_tag;
		end
	end

	// Read data registered; only written entries are ever walked
	always_ff @(posedge clk) begin
		rd_len <= len_mem[rd_addr];
		rd_tag <= tag_mem[rd_addr];
	end

endmodule

@@ hdl/ring_entry_offset_lookup_core.sv @@
// Top level of the ring entry offset lookup: ring pointers, walk sequencer, result register.
//
// A ring of DEPTH entries, each a length and a tag, held in a small memory
// with one write port and one registered read port. An add (s_tuser = 0)
// writes the entry at the write slot, overwriting the oldest entry when the
// ring is full, and returns the slot written. A find (s_tuser = 1) walks
// the stored entries oldest first through the one read port and one shared
// compare/subtract unit, one entry per cycle, until the byte offset lands
// inside an entry; it returns that slot, tag and the offset within it, or
// found = 0 when the offset lies past the stored data. A find on an empty
// ring returns found = 0 without a walk; otherwise it visits k (1..DEPTH)
// entries, the memory read port setting the one-entry-per-cycle pace. The
// block takes no new transfer while a find walks. The result sits in an
// output register, so the next input transfer is taken in the same cycle
// that the pending result is taken. No clearing pass is needed after
// reset: only written entries are ever visited.
module ring_entry_offset_lookup_core #(
	parameter int DEPTH    = 16,
	parameter int LEN_BITS = 12
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// Input stream
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// [11:0] entry_length, [43:12] entry_tag, [59:44] find_offset, [63:60] zero
	input  logic [reol_pkg::S_TDATA_W-1:0] s_tdata,
	// [0] func (0 add, 1 find)
	input  logic [reol_pkg::S_TUSER_W-1:0] s_tuser,
	// Result stream
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// [3:0] slot_index, [35:4] tag_out, [47:36] byte_offset
	output logic [reol_pkg::M_TDATA_W-1:0] m_tdata,
	// [0] found, [1] overwrote
	output logic [reol_pkg::M_TUSER_W-1:0] m_tuser
);
	import reol_pkg::*;

	localparam int SW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int LW = (LEN_BITS < ELEN_W) ? LEN_BITS : ELEN_W;

	// Input fields
	logic [ELEN_W-1:0] in_len;
	logic [TAG_W-1:0]  in_tag;
	logic [OFF_W-1:0]  in_off;
	logic [FUNC_W-1:0] in_func;

	assign in_len  = s_tdata[ELEN_W-1:0];
	assign in_tag  = s_tdata[ELEN_W+TAG_W-1:ELEN_W];
	assign in_off  = s_tdata[ELEN_W+TAG_W+OFF_W-1:ELEN_W+TAG_W];
	assign in_func = s_tuser[FUNC_W-1:0];

	// Ring state
	logic [SW-1:0] write_slot_q;
	logic [SW-1:0] read_slot_q;
	logic          ring_full_q;

	// Walk state
	seq_state_t       state_q;
	logic [SW-1:0]    idx_q;
	logic [CW-1:0]    remain_q;
	logic [OFF_W-1:0] off_q;

	// Result register
	logic                  out_valid_q;
	logic                  found_q;
	logic                  overwrote_q;
	logic [SLOT_OUT_W-1:0] slot_q;
	logic [TAG_W-1:0]      tag_q;
	logic [BOFF_W-1:0]     boff_q;

	// Store interface
	logic [SW-1:0]    rd_addr;
	logic [LW-1:0]    rd_len;
	logic [TAG_W-1:0] rd_tag;
	logic             wr_en;

	function automatic logic [SW-1:0] next_slot(input logic [SW-1:0] s);
		return (s == SW'(DEPTH - 1)) ? '0 : s + 1'b1;
	endfunction

	logic          in_xfer;
	logic          is_add;
	logic [SW-1:0] ws_next;
	logic [SW-1:0] rs_next;
	logic [CW-1:0] count;
	logic          hit;
	logic          last_entry;

	assign s_tready = (state_q == ST_IDLE) && (!out_valid_q || m_tready);
	assign in_xfer  = s_tvalid && s_tready;
	assign is_add   = (in_func == FUNC_ADD);
	assign wr_en    = in_xfer && is_add;

	assign ws_next = next_slot(write_slot_q);
	assign rs_next = ring_full_q ? next_slot(read_slot_q) : read_slot_q;

	// Number of stored entries
	always_comb begin
		if (ring_full_q) begin
			count = CW'(DEPTH);
		end else if (write_slot_q >= read_slot_q) begin
			count = CW'(write_slot_q - read_slot_q);
		end else begin
			count = CW'(DEPTH) - CW'(read_slot_q) + CW'(write_slot_q);
		end
	end

	// Idle: prefetch the oldest entry; walking: prefetch the one after idx_q
	assign rd_addr = (state_q == ST_WALK) ? next_slot(idx_q) : read_slot_q;

	// Shared compare unit: does the remaining offset fall in this entry
	assign hit        = (OFF_W'(rd_len) > off_q);
	assign last_entry = (remain_q == CW'(1));

	reol_store #(
		.DEPTH (DEPTH),
		.LW    (LW),
		.SW    (SW)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (write_slot_q),
		.wr_len  (LW'(in_len)),
		.wr_tag  (in_tag),
		.rd_addr (rd_addr),
		.rd_len  (rd_len),
		.rd_tag  (rd_tag)
	);

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			write_slot_q <= '0;
			read_slot_q  <= '0;
			ring_full_q  <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						if (is_add) begin
							write_slot_q <= ws_next;
							read_slot_q  <= rs_next;
							ring_full_q  <= (ws_next == rs_next);
							out_valid_q  <= 1'b1;
						end else if (count == '0) begin
							out_valid_q <= 1'b1;
						end else begin
							state_q <= ST_WALK;
						end
					end
				end
				ST_WALK: begin
					if (hit || last_entry) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Walk and result payload
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					idx_q    <= read_slot_q;
					remain_q <= count;
					off_q    <= in_off;
					found_q  <= 1'b0;
					tag_q    <= '0;
					boff_q   <= '0;
					if (is_add) begin
						slot_q      <= SLOT_OUT_W'(write_slot_q);
						overwrote_q <= ring_full_q;
					end else begin
						slot_q      <= '0;
						overwrote_q <= 1'b0;
					end
				end
			end
			ST_WALK: begin
				if (hit) begin
					found_q <= 1'b1;
					slot_q  <= SLOT_OUT_W'(idx_q);
					tag_q   <= rd_tag;
					boff_q  <= off_q[BOFF_W-1:0];
				end else begin
					// miss leaves the zero result loaded at accept
					off_q    <= off_q - OFF_W'(rd_len);
					idx_q    <= next_slot(idx_q);
					remain_q <= remain_q - 1'b1;
				end
			end
			default: begin
				idx_q <= idx_q;
			end
		endcase
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {boff_q, tag_q, slot_q};
	assign m_tuser  = {overwrote_q, found_q};

endmodule
